@@ design/lbsg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbsg_pkg: shared types and constants
// Item and result structs, command codes and arithmetic widths of the
// table-lookup bit-serial matrix-vector engine.
// ----------------------------------------------------------------------------
package lbsg_pkg;

	localparam int unsigned MAX_K_DEF = 1024;
	localparam int unsigned ENTRY_W   = 19;
	localparam int unsigned PLANE_W   = 26;
	localparam int unsigned ROW_W     = 48;
	localparam int unsigned VL_W      = 11;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned MUL_W     = 16 + PLANE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE   = 1'd1;
	localparam logic [VL_W-1:0]      VL_RESET          = 11'd1024;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_WORD  = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic [9:0]         act_index;
		logic signed [15:0] act_value;
		logic [15:0]        row_index;
		logic signed [15:0] bias;
		logic [4:0]         word_index;
		logic [31:0]        weight_word;
		logic signed [15:0] alpha;
		logic               plane_last;
		logic               row_last;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        row_tag;
		logic signed [47:0] row_value;
		logic               saturated;
	} result_t;

	typedef enum logic [1:0] {
		TK_LOAD,
		TK_START,
		TK_WORD
	} task_kind_t;

	// classified work handed from front to back
	typedef struct packed {
		task_kind_t kind;
		logic       rebuild;
		in_item_t   item;
	} task_t;

endpackage

@@ design/lut_bit_serial_gemv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut_bit_serial_gemv: table-lookup bit-serial matrix-vector engine
// Activations load one per item; a load to index 8n+7 rebuilds a 256-entry
// signed-sum table, weight words index four tables at once and bit planes are
// scaled by alpha into a saturating 48-bit row result.
// ----------------------------------------------------------------------------
// Work per item in the execution back end, behind a two-entry input queue:
// an ignored command or an out-of-range load is dropped before the queue; a
// load writes the store and, when it closes a chunk, also does 8 store reads
// plus 256 table writes, one entry a cycle through the single write port of
// the table bank; a start row takes one chunk total read a cycle over the
// chunks in use; a weight word does a bank read and plane add, then an alpha
// multiply and saturating row add when it ends a plane or a row.
// Results wait in a two-entry queue. No clearing pass is needed after reset.
module lut_bit_serial_gemv #(
	parameter int unsigned MAX_K = lbsg_pkg::MAX_K_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  lbsg_pkg::in_item_t             item,
	output logic                           empty,
	input  logic                           pop,
	output lbsg_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [lbsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lbsg_pkg::VL_W-1:0]      cfg_data
);
	import lbsg_pkg::*;

	logic    tk_valid, tk_pop, res_push, res_full;
	task_t   tk;
	result_t res_out;

	lbsg_front #(.MAX_K(MAX_K)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.tk_valid(tk_valid), .tk(tk), .tk_pop(tk_pop)
	);

	lbsg_back #(.MAX_K(MAX_K)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .tk_valid(tk_valid), .tk(tk), .tk_pop(tk_pop),
		.res_push(res_push), .res_full(res_full), .res_out(res_out)
	);

	lbsg_rq u_rq (
		.clk(clk), .arst_n(arst_n), .res_push(res_push), .res_full(res_full),
		.res_in(res_out), .empty(empty), .pop(pop), .result(result)
	);

endmodule

@@ design/lbsg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbsg_front: input acceptance and classification
// Takes one item per transfer, drops items with no effect and queues the
// rest (two entries) for the execution back end.
// ----------------------------------------------------------------------------
module lbsg_front #(
	parameter int unsigned MAX_K = lbsg_pkg::MAX_K_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  lbsg_pkg::in_item_t item,
	output logic               tk_valid,
	output lbsg_pkg::task_t    tk,
	input  logic               tk_pop
);
	import lbsg_pkg::*;

	task_t      slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       keep, enq, deq;
	task_t      cls;

	// classify the incoming item
	always_comb begin
		cls.item    = item;
		cls.rebuild = (item.act_index[2:0] == 3'b111);
		cls.kind    = TK_LOAD;
		keep        = 1'b0;
		case (item.command)
			CMD_LOAD: begin
				cls.kind = TK_LOAD;
				keep     = (32'(item.act_index) < 32'(MAX_K));
			end
			CMD_START: begin
				cls.kind = TK_START;
				keep     = 1'b1;
			end
			CMD_WORD: begin
				cls.kind = TK_WORD;
				keep     = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign full     = (count_q == 2'd2);
	assign tk_valid = (count_q != 2'd0);
	assign tk       = slot_q[rd_ptr_q];
	assign enq      = push && !full && keep;
	assign deq      = tk_pop && tk_valid;

	// queue payload
	always_ff @(posedge clk) begin
		if (enq) slot_q[wr_ptr_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (enq) wr_ptr_q <= !wr_ptr_q;
			if (deq) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(enq) - 2'(deq);
		end
	end

endmodule

@@ design/lbsg_rq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbsg_rq: result queue
// Two-entry queue that holds finished row results until they are taken.
// ----------------------------------------------------------------------------
module lbsg_rq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_push,
	output logic              res_full,
	input  lbsg_pkg::result_t res_in,
	output logic              empty,
	input  logic              pop,
	output lbsg_pkg::result_t result
);
	import lbsg_pkg::*;

	result_t    slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       enq, deq;

	assign res_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign result   = slot_q[rd_ptr_q];
	assign enq      = res_push && !res_full;
	assign deq      = pop && !empty;

	always_ff @(posedge clk) begin
		if (enq) slot_q[wr_ptr_q] <= res_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (enq) wr_ptr_q <= !wr_ptr_q;
			if (deq) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(enq) - 2'(deq);
		end
	end

endmodule

@@ design/lbsg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbsg_back: execution back end
// Holds the activation store, the lookup tables in four banks and the chunk
// totals; rebuilds tables, seeds rows and accumulates weight words.
// ----------------------------------------------------------------------------
module lbsg_back #(
	parameter int unsigned MAX_K = lbsg_pkg::MAX_K_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lbsg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lbsg_pkg::VL_W-1:0]            cfg_data,
	input  logic                                 tk_valid,
	input  lbsg_pkg::task_t                      tk,
	output logic                                 tk_pop,
	output logic                                 res_push,
	input  logic                                 res_full,
	output lbsg_pkg::result_t                    res_out
);
	import lbsg_pkg::*;

	localparam int unsigned WORDS  = MAX_K / 32;
	localparam int unsigned CHUNKS = MAX_K / 8;
	localparam int unsigned AW     = $clog2(MAX_K);
	localparam int unsigned CW     = $clog2(CHUNKS);
	localparam int unsigned NCW    = CW + 1;
	localparam int unsigned WA     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned BA     = WA + 8;
	localparam int unsigned BANK_D = WORDS * 256;
	localparam int unsigned EW     = $clog2(WORDS + 1);
	localparam int unsigned TOT_W  = ENTRY_W + CW;
	localparam int unsigned BP_W   = 16 + TOT_W;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_GATHER = 10'b0000000010,
		S_BUILD  = 10'b0000000100,
		S_TOTAL  = 10'b0000001000,
		S_BIAS   = 10'b0000010000,
		S_WREAD  = 10'b0000100000,
		S_WSUM   = 10'b0001000000,
		S_WMUL   = 10'b0010000000,
		S_WADD   = 10'b0100000000,
		S_EMIT   = 10'b1000000000
	} state_t;

	state_t                    state_q;
	logic [VL_W-1:0]           vl_q;
	logic                      bias_en_q;
	in_item_t                  cur_q;
	logic [CW-1:0]             chunk_q;
	logic [3:0]                gcnt_q;
	logic [7:0]                ecnt_q;
	logic [NCW-1:0]            tcnt_q;
	logic                      grd_q, trd_q;
	logic signed [15:0]        acts_q [8];
	logic signed [15:0]        act_rdata_q;
	logic signed [ENTRY_W-1:0] tot_rdata_q;
	logic signed [ENTRY_W-1:0] bank_rd_q [4];
	logic signed [TOT_W-1:0]   tot_q;
	logic signed [PLANE_W-1:0] plane_q;
	logic signed [MUL_W-1:0]   prod_q;
	logic signed [ROW_W-1:0]   row_q;
	logic                      clip_q;
	logic [15:0]               tag_q;

	logic signed [15:0]        act_mem [MAX_K];
	logic signed [ENTRY_W-1:0] tot_mem [CHUNKS];
	logic signed [ENTRY_W-1:0] bank_mem [4][BANK_D];

	logic [EW-1:0]             eff_words;
	logic [NCW-1:0]            n_chunks;
	logic                      word_in_use;
	logic                      act_we, tbl_we;
	logic [AW-1:0]             act_raddr;
	logic [BA-1:0]             wr_addr, rd_addr;
	logic signed [19:0]        entry_raw;
	logic signed [ENTRY_W-1:0] entry;
	logic signed [PLANE_W-1:0] plane_nx;
	logic signed [BP_W-1:0]    bias_prod;
	logic signed [ROW_W:0]     row_wide;
	logic signed [ROW_W-1:0]   row_sat;
	logic                      row_clip;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_q      <= VL_RESET;
			bias_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VECTOR_LENGTH: vl_q      <= cfg_data;
				CFG_BIAS_ENABLE:   bias_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// groups and chunks in use
	assign eff_words   = (32'(vl_q) > 32'(MAX_K)) ? EW'(WORDS) : EW'(vl_q >> 5);
	assign n_chunks    = NCW'({eff_words, 2'b00});
	assign word_in_use = (32'(cur_q.word_index) < 32'(eff_words));

	assign tk_pop = tk_valid && (state_q == S_IDLE);
	assign act_we = tk_pop && (tk.kind == TK_LOAD);
	assign tbl_we = (state_q == S_BUILD);

	// activation store
	assign act_raddr = AW'({chunk_q, gcnt_q[2:0]});
	always_ff @(posedge clk) begin
		if (act_we) act_mem[AW'(tk.item.act_index)] <= tk.item.act_value;
		act_rdata_q <= act_mem[act_raddr];
	end

	// table entry for the current index: +x on set bits, -x on clear bits
	always_comb begin
		entry_raw = '0;
		for (int i = 0; i < 8; i++) begin
			entry_raw = entry_raw + (ecnt_q[i] ? 20'(acts_q[i]) : -20'(acts_q[i]));
		end
		if (entry_raw > 20'sd262143)       entry = 19'sd262143;
		else if (entry_raw < -20'sd262144) entry = -19'sd262144;
		else                               entry = ENTRY_W'(entry_raw);
	end

	// chunk totals (entry 255 of each table)
	always_ff @(posedge clk) begin
		if (tbl_we && ecnt_q == 8'hFF) tot_mem[chunk_q] <= entry;
		tot_rdata_q <= tot_mem[CW'(tcnt_q)];
	end

	// lookup banks: bank j serves chunk 4*word+j
	assign wr_addr = BA'({WA'(chunk_q >> 2), ecnt_q});
	assign rd_addr = BA'({WA'(cur_q.word_index), 8'h00});
	for (genvar b = 0; b < 4; b++) begin : g_bank
		always_ff @(posedge clk) begin
			if (tbl_we && chunk_q[1:0] == 2'(b)) bank_mem[b][wr_addr] <= entry;
			bank_rd_q[b] <= bank_mem[b][rd_addr | BA'(cur_q.weight_word[8*b +: 8])];
		end
	end

	// plane accumulation, products and row saturation
	always_comb begin
		plane_nx = plane_q;
		if (word_in_use) begin
			for (int b = 0; b < 4; b++) plane_nx = plane_nx + PLANE_W'(bank_rd_q[b]);
		end
		bias_prod = cur_q.bias * tot_q;
		row_wide  = (ROW_W+1)'(row_q) + (ROW_W+1)'(prod_q);
		row_clip  = (row_wide[ROW_W] != row_wide[ROW_W-1]);
		if (!row_clip)          row_sat = ROW_W'(row_wide);
		else if (row_wide[ROW_W]) row_sat = {1'b1, {(ROW_W-1){1'b0}}};
		else                    row_sat = {1'b0, {(ROW_W-1){1'b1}}};
	end

	assign res_push          = (state_q == S_EMIT) && !res_full;
	assign res_out.row_tag   = tag_q;
	assign res_out.row_value = row_q;
	assign res_out.saturated = clip_q;

	// payload of the current task and gathered activations
	always_ff @(posedge clk) begin
		if (tk_pop) cur_q <= tk.item;
		if (grd_q) begin
			for (int i = 0; i < 7; i++) acts_q[i] <= acts_q[i+1];
			acts_q[7] <= act_rdata_q;
		end
		if (state_q == S_WMUL) prod_q <= cur_q.alpha * plane_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chunk_q <= '0;
			gcnt_q  <= '0;
			ecnt_q  <= '0;
			tcnt_q  <= '0;
			grd_q   <= 1'b0;
			trd_q   <= 1'b0;
			tot_q   <= '0;
			plane_q <= '0;
			row_q   <= '0;
			clip_q  <= 1'b0;
			tag_q   <= '0;
		end else begin
			grd_q <= (state_q == S_GATHER) && (gcnt_q < 4'd8);
			trd_q <= (state_q == S_TOTAL) && (tcnt_q < n_chunks);
			case (state_q)
				S_IDLE: begin
					if (tk_pop) begin
						case (tk.kind)
							TK_LOAD: begin
								chunk_q <= CW'(tk.item.act_index >> 3);
								gcnt_q  <= '0;
								if (tk.rebuild) state_q <= S_GATHER;
							end
							TK_START: begin
								tag_q   <= tk.item.row_index;
								tcnt_q  <= '0;
								tot_q   <= '0;
								state_q <= S_TOTAL;
							end
							TK_WORD: state_q <= S_WREAD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_GATHER: begin
					if (gcnt_q == 4'd8) begin
						ecnt_q  <= '0;
						state_q <= S_BUILD;
					end else begin
						gcnt_q <= gcnt_q + 4'd1;
					end
				end
				S_BUILD: begin
					ecnt_q <= ecnt_q + 8'd1;
					if (ecnt_q == 8'hFF) state_q <= S_IDLE;
				end
				S_TOTAL: begin
					if (tcnt_q < n_chunks) tcnt_q <= tcnt_q + NCW'(1);
					if (trd_q) tot_q <= tot_q + TOT_W'(tot_rdata_q);
					if (tcnt_q == n_chunks && !trd_q) state_q <= S_BIAS;
				end
				S_BIAS: begin
					row_q   <= bias_en_q ? ROW_W'(bias_prod) : '0;
					plane_q <= '0;
					clip_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				S_WREAD: state_q <= S_WSUM;
				S_WSUM: begin
					plane_q <= plane_nx;
					state_q <= (cur_q.plane_last || cur_q.row_last) ? S_WMUL : S_IDLE;
				end
				S_WMUL: begin
					plane_q <= '0;
					state_q <= S_WADD;
				end
				S_WADD: begin
					row_q   <= row_sat;
					clip_q  <= clip_q || row_clip;
					state_q <= cur_q.row_last ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (!res_full) begin
						row_q   <= '0;
						plane_q <= '0;
						clip_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result transfer into a full queue");
	a_build_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUILD && ecnt_q == 8'hFF) |=> (state_q == S_IDLE))
		else $error("table rebuild did not finish after the last entry");
	a_plane_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WMUL) |=> (plane_q == '0)) else $error("plane sum not cleared");
	a_row_clr: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (row_q == '0 && !clip_q)) else $error("row not cleared after result");

endmodule

@@ verif/tb_lut_bit_serial_gemv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lut_bit_serial_gemv: self-checking bench of the table-lookup GEMV engine
// Loads the first 256 activations, then drives directed rows (table clipping,
// plane wrap, groups out of use, row end without plane end, ignored commands)
// and random rows under several length and bias settings. A behavioural
// predictor keeps its own store, tables and accumulators and queues the
// expected row results; every result transfer is checked field by field
// against the oldest one.
// ----------------------------------------------------------------------------
module tb_lut_bit_serial_gemv;
	import lbsg_pkg::*;

	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam longint     ROW_MAX     = 64'sd140737488355327;
	localparam longint     ROW_MIN     = -ROW_MAX - 1;
	localparam int         STALL_LIMIT = 20000;
	localparam int         SETTLE      = 1000;
	localparam int         LOADED      = 256;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	in_item_t             item;
	logic                 empty;
	logic                 pop;
	result_t              result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VL_W-1:0]      cfg_data;

	// predictor state
	int                   act_mem[1024];
	int                   pred_tbl[128*256];
	longint               act_total;
	longint               plane_acc;
	longint               row_acc;
	logic [15:0]          cur_row;
	bit                   row_clip;
	int unsigned          vec_len;
	bit                   bias_on;

	result_t              row_results_q[$];
	int                   errors;
	int                   send_idle_pct;
	int                   recv_idle_pct;
	int                   stall_cnt;

	lut_bit_serial_gemv u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---- predictor ----
	function automatic int unsigned chunks_used();
		int unsigned n;
		n = (vec_len > 1024) ? 1024 : vec_len;
		n = n & ~32'd31;
		return n / 8;
	endfunction

	function automatic void rebuild_chunk(int unsigned c);
		int t[256];
		int base;
		int twice;
		int unsigned step;
		base = 0;
		for (int i = 0; i < 8; i++) base -= act_mem[c*8+i];
		t[0] = base;
		for (int s = 0; s < 8; s++) begin
			twice = 2 * act_mem[c*8+s];
			step = 1 << s;
			for (int i = 0; i < step; i++) t[step+i] = t[i] + twice;
		end
		// entries clip to 19 bits signed
		for (int i = 0; i < 256; i++)
			pred_tbl[c*256+i] = (t[i] > 262143) ? 262143 :
				(t[i] < -262144) ? -262144 : t[i];
	endfunction

	function automatic void row_accumulate(longint a);
		longint r;
		r = row_acc + a;
		if (r > ROW_MAX) begin
			r = ROW_MAX;
			row_clip = 1'b1;
		end
		if (r < ROW_MIN) begin
			r = ROW_MIN;
			row_clip = 1'b1;
		end
		row_acc = r;
	endfunction

	function automatic void predict_row(in_item_t it);
		int unsigned n;
		int unsigned c;
		longint ps;
		logic signed [25:0] wrapped;
		bit plane_end;
		result_t r;
		n = chunks_used();
		case (it.command)
			CMD_LOAD: begin
				act_mem[it.act_index] = int'($signed(it.act_value));
				if (it.act_index[2:0] == 3'd7) rebuild_chunk(it.act_index / 8);
			end
			CMD_START: begin
				act_total = 0;
				for (c = 0; c < n; c++) act_total += pred_tbl[c*256+255];
				cur_row = it.row_index;
				plane_acc = 0;
				row_clip = 1'b0;
				row_acc = bias_on ? longint'($signed(it.bias)) * act_total : 0;
			end
			CMD_WORD: begin
				ps = plane_acc;
				for (int j = 0; j < 4; j++) begin
					c = it.word_index * 4 + j;
					if (c < n) ps += pred_tbl[c*256 + it.weight_word[8*j +: 8]];
				end
				wrapped = ps[25:0];
				plane_acc = wrapped;
				plane_end = it.plane_last | it.row_last;
				if (plane_end) begin
					row_accumulate(longint'($signed(it.alpha)) * plane_acc);
					plane_acc = 0;
				end
				if (it.row_last) begin
					r.row_tag = cur_row;
					r.row_value = row_acc[47:0];
					r.saturated = row_clip;
					row_results_q.push_back(r);
					row_acc = 0;
					plane_acc = 0;
					row_clip = 1'b0;
				end
			end
			default: ;
		endcase
	endfunction

	// ---- result transfers ----
	always @(negedge clk) pop <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		result_t exp_r;
		if (pop && !empty) begin
			if (row_results_q.size() == 0) begin
				$error("row result with none expected: tag %0d", result.row_tag);
				errors++;
			end else begin
				exp_r = row_results_q.pop_front();
				if (result.row_tag !== exp_r.row_tag) begin
					$error("row_tag: expected %0d, got %0d", exp_r.row_tag, result.row_tag);
					errors++;
				end
				if (result.row_value !== exp_r.row_value) begin
					$error("row_value: expected %0d, got %0d",
						exp_r.row_value, result.row_value);
					errors++;
				end
				if (result.saturated !== exp_r.saturated) begin
					$error("saturated: expected %0b, got %0b",
						exp_r.saturated, result.saturated);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("** lut_bit_serial_gemv: FAILED **");
			$finish;
		end
	end

	// ---- stimulus helpers ----
	// called at a falling edge, returns at a falling edge with push left high
	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		item = it;
		do @(posedge clk); while (full);
		predict_row(it);
		@(negedge clk);
	endtask

	// waits long enough for three rebuilding loads still queued in the block
	task automatic drain();
		push = 1'b0;
		wait (row_results_q.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VL_W-1:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_VECTOR_LENGTH) vec_len = val;
		else bias_on = val[0];
	endtask

	function automatic in_item_t rand_item();
		logic [127:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom};
		return in_item_t'(bits[$bits(in_item_t)-1:0]);
	endfunction

	function automatic in_item_t load_cmd(logic [9:0] idx, logic [15:0] val);
		in_item_t it;
		it = rand_item();
		it.command = CMD_LOAD;
		it.act_index = idx;
		it.act_value = val;
		return it;
	endfunction

	function automatic in_item_t start_cmd(logic [15:0] tag, logic [15:0] b);
		in_item_t it;
		it = rand_item();
		it.command = CMD_START;
		it.row_index = tag;
		it.bias = b;
		return it;
	endfunction

	function automatic in_item_t word_cmd(logic [4:0] wi, logic [31:0] w,
		logic [15:0] a, bit pl, bit rl);
		in_item_t it;
		it = rand_item();
		it.command = CMD_WORD;
		it.word_index = wi;
		it.weight_word = w;
		it.alpha = a;
		it.plane_last = pl;
		it.row_last = rl;
		return it;
	endfunction

	// ---- tests ----
	// fill the first eight groups so that every table in use is built before
	// any lookup; chunks 0-3 at the positive limit, chunks 4-7 at the negative
	task automatic test_load_store();
		logic [15:0] v;
		for (int i = 0; i < LOADED; i++) begin
			if (i < 32) v = 16'sh7fff;
			else if (i < 64) v = 16'sh8000;
			else v = 16'($urandom);
			send_item(load_cmd(10'(i), v));
		end
	endtask

	task automatic test_directed();
		in_item_t it;
		write_reg(CFG_VECTOR_LENGTH, VL_W'(LOADED));
		write_reg(CFG_BIAS_ENABLE, VL_W'(1));
		send_item(start_cmd(16'hffff, 16'sh7fff));
		// clipped table entry: all eight at the negative limit, index zero
		send_item(word_cmd(5'd1, 32'h0, 16'sh8000, 1'b1, 1'b0));
		// group beyond the length in use contributes nothing
		send_item(word_cmd(5'd31, 32'hffffffff, 16'sh7fff, 1'b1, 1'b0));
		// ignored command in the middle of a row
		it = rand_item();
		it.command = CMD_IGNORED;
		send_item(it);
		send_item(word_cmd(5'd0, 32'hffffffff, 16'sh8000, 1'b0, 1'b0));
		// row end without plane end closes the plane
		send_item(word_cmd(5'd2, 32'h5a5aa5a5, 16'sh1000, 1'b0, 1'b1));
		send_item(start_cmd(16'h0000, 16'sh8000));
		send_item(word_cmd(5'd16, 32'h00ff00ff, 16'sh0000, 1'b1, 1'b1));
		// words with no start row accumulate from zero
		send_item(word_cmd(5'd3, 32'h12345678, 16'sh0001, 1'b1, 1'b1));
		// shortest length: groups beyond the first contribute nothing
		write_reg(CFG_VECTOR_LENGTH, 11'd32);
		write_reg(CFG_BIAS_ENABLE, VL_W'(0));
		send_item(start_cmd(16'h00a5, 16'sh7fff));
		send_item(word_cmd(5'd0, 32'h80402010, 16'sh7fff, 1'b1, 1'b0));
		send_item(word_cmd(5'd1, 32'hffffffff, 16'sh7fff, 1'b1, 1'b1));
	endtask

	// plane sum wraps past 26 bits within one plane
	task automatic test_plane_wrap();
		write_reg(CFG_VECTOR_LENGTH, VL_W'(LOADED));
		write_reg(CFG_BIAS_ENABLE, VL_W'(1));
		send_item(start_cmd(16'h0c1f, 16'sh8000));
		for (int w = 0; w < 33; w++)
			send_item(word_cmd(5'd0, 32'hffffffff, 16'sh7fff, w == 32, w == 32));
		drain();
	endtask

	task automatic random_rows(int unsigned count);
		int unsigned sent;
		int unsigned planes;
		int unsigned words;
		int unsigned pick;
		in_item_t it;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_item(load_cmd(10'($urandom_range(LOADED - 1)), 16'($urandom)));
				sent++;
			end else if (pick < 12) begin
				it = rand_item();
				it.command = CMD_IGNORED;
				send_item(it);
			end else if (pick < 16) begin
				send_item(word_cmd(5'($urandom), $urandom, 16'($urandom),
					1'($urandom_range(1)), 1'($urandom_range(1))));
				sent++;
			end else begin
				send_item(start_cmd(16'($urandom), 16'($urandom)));
				sent++;
				planes = $urandom_range(1, 4);
				for (int p = 0; p < planes; p++) begin
					words = $urandom_range(1, 6);
					for (int w = 0; w < words; w++) begin
						send_item(word_cmd(5'($urandom), $urandom, 16'($urandom),
							(w == words - 1) && (p != planes - 1 || $urandom_range(1)),
							(p == planes - 1) && (w == words - 1)));
						sent++;
					end
				end
			end
		end
	endtask

	task automatic test_random();
		int unsigned vl;
		for (int mode = 0; mode < 3; mode++) begin
			drain();
			send_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 66 : 0;
			recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 35 : 0;
			for (int s = 0; s < 3; s++) begin
				vl = (s == 0) ? LOADED : (s == 1) ? 32 : $urandom_range(32, LOADED);
				write_reg(CFG_VECTOR_LENGTH, VL_W'(vl));
				write_reg(CFG_BIAS_ENABLE, VL_W'($urandom_range(1)));
				random_rows(50);
			end
		end
	endtask

	// ---- sequence ----
	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_VECTOR_LENGTH;
		cfg_data = '0;
		errors = 0;
		stall_cnt = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		act_total = 0;
		plane_acc = 0;
		row_acc = 0;
		cur_row = '0;
		row_clip = 1'b0;
		vec_len = VL_RESET;
		bias_on = 1'b1;
		foreach (act_mem[i]) act_mem[i] = 0;
		foreach (pred_tbl[i]) pred_tbl[i] = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_load_store();
		test_directed();
		test_plane_wrap();
		test_random();
		drain();

		if (errors == 0) $display("** lut_bit_serial_gemv: PASSED **");
		else $display("** lut_bit_serial_gemv: FAILED **");
		$finish;
	end

endmodule
